[rtl/animation_timer_bank_defines.svh]
// Assertion macros shared by the animation timer bank RTL.
`ifndef ANIMATION_TIMER_BANK_DEFINES_SVH
`define ANIMATION_TIMER_BANK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atb: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atb: next-cycle check failed");

`endif

[rtl/atb_pkg.sv]
// Shared types, codes and constants of the animation timer bank.
package atb_pkg;

   // Default channel count and limits.
   localparam int CHANNELS_DEF = 16;
   localparam logic [15:0] TIME_SCALE_RESET = 16'd1;
   localparam logic [15:0] TIME_SCALE_MAX = 16'd32768;
   localparam logic [16:0] PROGRESS_FULL = 17'h10000;

   // Serial divider: one quotient bit per cycle.
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Input item kinds.
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_FIND  = 2'd3
   } kind_type;

   // Configuration register indexes.
   localparam logic [1:0] REG_TIME_SCALE = 2'd0;
   localparam logic [1:0] REG_RUNNING = 2'd1;

   // Result codes.
   localparam logic RK_UPDATE = 1'b0;
   localparam logic RK_FIND = 1'b1;
   localparam logic [1:0] PHASE_STARTED = 2'd0;
   localparam logic [1:0] PHASE_PROGRESS = 2'd1;
   localparam logic [1:0] PHASE_COMPLETED = 2'd2;

   // Classified input item as queued between front and back.
   typedef struct packed {
      kind_type    kind;
      logic [5:0]  channel;
      logic [15:0] duration;
      logic [31:0] now_ms;
      logic        in_range;
   } item_type;

   // One result item.
   typedef struct packed {
      logic        result_kind;
      logic [5:0]  channel_index;
      logic [1:0]  phase;
      logic [16:0] progress;
      logic        found;
      logic        last;
   } result_type;

   // Divider request and response.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

[rtl/atb_front.sv]
// Front end: accepts input items, classifies them and queues them for the back end.
module atb_front #(
   parameter int CHANNELS = atb_pkg::CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_kind,
   input  logic [5:0]         req_channel,
   input  logic [15:0]        req_duration,
   input  logic [31:0]        req_now_ms,
   output logic               item_valid,
   output atb_pkg::item_type  item,
   input  logic               item_take
);

   localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

   atb_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;
   atb_pkg::item_type new_item;

   // Classify the incoming item.
   always_comb begin
      new_item.kind = atb_pkg::kind_type'(req_kind);
      new_item.channel = req_channel;
      new_item.duration = req_duration;
      new_item.now_ms = req_now_ms;
      new_item.in_range = {1'b0, req_channel} < CH_LIMIT;
   end

   // Queue control.
   assign req_full = count_ff == 2'd2;
   assign item_valid = count_ff != 2'd0;
   assign item = entry_ff[rd_ptr_ff];
   assign do_push = req_push && !req_full;
   assign do_pop = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[rtl/atb_div.sv]
// Restoring serial divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
module atb_div (
   input  logic                  clock,
   input  logic                  reset,
   input  atb_pkg::div_req_type  req,
   output atb_pkg::div_rsp_type  rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [atb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;
   logic        ge;

   // One shift-and-subtract step per cycle.
   always_comb begin
      trial = {rem_ff, quo_ff[31]};
      ge = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = atb_pkg::DIV_CNT_W'(atb_pkg::DIV_STEPS - 1);
         quo_in = req.dividend;
         rem_in = 16'd0;
         dvs_in = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], ge};
         rem_in = ge ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[rtl/atb_back.sv]
// Back end: channel state, configuration, tick walk and free-channel search.
module atb_back #(
   parameter int CHANNELS = atb_pkg::CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data,
   input  logic                  item_valid,
   input  atb_pkg::item_type     item,
   output logic                  item_take,
   output atb_pkg::div_req_type  div_req,
   input  atb_pkg::div_rsp_type  div_rsp,
   output logic                  rsp_push,
   output atb_pkg::result_type   rsp_data,
   input  logic                  rsp_full
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_TDIV = 6'b000010,
      ST_WALK = 6'b000100,
      ST_PDIV = 6'b001000,
      ST_EMIT = 6'b010000,
      ST_FIND = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     after_ff, after_in;
   logic [31:0]          qdelta_ff, qdelta_in;
   logic [31:0]          last_time_ff, last_time_in;
   logic [CHANNELS-1:0]  active_ff, active_in;
   logic [15:0]          scale_ff, scale_in;
   logic                 running_ff, running_in;
   atb_pkg::result_type  res_ff, res_in;
   logic [15:0]          rem_ff [CHANNELS];
   logic [15:0]          tot_ff [CHANNELS];

   logic                 arr_we;
   logic                 tot_we;
   logic [IDX_W-1:0]     arr_idx;
   logic [15:0]          rem_wdata;
   logic [15:0]          tot_wdata;
   logic [15:0]          cur_rem, cur_tot;
   logic [CHANNELS-1:0]  above;
   logic                 last_flag;
   logic [31:0]          delta;
   logic [IDX_W-1:0]     item_idx;
   logic [IDX_W-1:0]     find_after;

   // Wrapping increment of a channel index.
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] v);
      next_idx = (v == LAST_IDX) ? '0 : IDX_W'(v + 1'b1);
   endfunction

   // Current channel and whether any later channel is still active.
   always_comb begin
      cur_rem = rem_ff[idx_ff];
      cur_tot = tot_ff[idx_ff];
      for (int j = 0; j < CHANNELS; j++) begin
         above[j] = IDX_W'(j) > idx_ff;
      end
      last_flag = ~|(active_ff & above);
      delta = item.now_ms - last_time_ff;
      item_idx = item.channel[IDX_W-1:0];
      find_after = item.in_range ? item_idx : LAST_IDX;
   end

   assign csr_ready = 1'b1;

   // Configuration writes, with the time scale clamped to its range.
   always_comb begin
      scale_in = scale_ff;
      running_in = running_ff;
      if (csr_valid) begin
         unique case (csr_index)
            atb_pkg::REG_TIME_SCALE: begin
               if (csr_data == 16'd0) begin
                  scale_in = 16'd1;
               end else if (csr_data > atb_pkg::TIME_SCALE_MAX) begin
                  scale_in = atb_pkg::TIME_SCALE_MAX;
               end else begin
                  scale_in = csr_data;
               end
            end
            atb_pkg::REG_RUNNING: running_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      after_in = after_ff;
      qdelta_in = qdelta_ff;
      last_time_in = last_time_ff;
      active_in = active_ff;
      res_in = res_ff;
      item_take = 1'b0;
      div_req = '0;
      arr_we = 1'b0;
      tot_we = 1'b0;
      arr_idx = idx_ff;
      rem_wdata = 16'd0;
      tot_wdata = 16'd0;
      rsp_push = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               unique case (item.kind)
                  atb_pkg::KIND_TICK: begin
                     if (running_ff && (delta >= {16'd0, scale_ff})) begin
                        div_req.start = 1'b1;
                        div_req.dividend = delta;
                        div_req.divisor = scale_ff;
                        last_time_in = item.now_ms;
                        state_in = ST_TDIV;
                     end
                  end
                  atb_pkg::KIND_START: begin
                     if (item.in_range) begin
                        if (active_ff == '0) begin
                           last_time_in = item.now_ms;
                        end
                        arr_we = 1'b1;
                        tot_we = 1'b1;
                        arr_idx = item_idx;
                        rem_wdata = (item.duration == 16'd0) ? 16'd1 : item.duration;
                        tot_wdata = rem_wdata;
                        active_in[item_idx] = 1'b1;
                     end
                  end
                  atb_pkg::KIND_STOP: begin
                     if (item.in_range) begin
                        active_in[item_idx] = 1'b0;
                     end
                  end
                  atb_pkg::KIND_FIND: begin
                     after_in = find_after;
                     idx_in = next_idx(find_after);
                     state_in = ST_FIND;
                  end
                  default: ;
               endcase
            end
         end
         ST_TDIV: begin
            if (div_rsp.done) begin
               qdelta_in = div_rsp.quotient;
               idx_in = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (active_ff[idx_ff]) begin
               if ({16'd0, cur_rem} > qdelta_ff) begin
                  div_req.start = 1'b1;
                  div_req.dividend = {16'(cur_tot - cur_rem), 16'd0};
                  div_req.divisor = cur_tot;
                  state_in = ST_PDIV;
               end else begin
                  active_in[idx_ff] = 1'b0;
                  res_in.result_kind = atb_pkg::RK_UPDATE;
                  res_in.channel_index = 6'(idx_ff);
                  res_in.phase = atb_pkg::PHASE_COMPLETED;
                  res_in.progress = atb_pkg::PROGRESS_FULL;
                  res_in.found = 1'b0;
                  res_in.last = last_flag;
                  state_in = ST_EMIT;
               end
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = next_idx(idx_ff);
            end
         end
         ST_PDIV: begin
            if (div_rsp.done) begin
               res_in.result_kind = atb_pkg::RK_UPDATE;
               res_in.channel_index = 6'(idx_ff);
               res_in.phase = (cur_rem == cur_tot) ? atb_pkg::PHASE_STARTED
                                                   : atb_pkg::PHASE_PROGRESS;
               res_in.progress = div_rsp.quotient[16:0];
               res_in.found = 1'b0;
               res_in.last = last_flag;
               arr_we = 1'b1;
               rem_wdata = cur_rem - qdelta_ff[15:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (res_ff.last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = next_idx(idx_ff);
                  state_in = ST_WALK;
               end
            end
         end
         ST_FIND: begin
            res_in.result_kind = atb_pkg::RK_FIND;
            res_in.phase = atb_pkg::PHASE_STARTED;
            res_in.progress = 17'd0;
            res_in.last = 1'b1;
            if (!active_ff[idx_ff]) begin
               res_in.channel_index = 6'(idx_ff);
               res_in.found = 1'b1;
               state_in = ST_EMIT;
            end else if (idx_ff == after_ff) begin
               res_in.channel_index = 6'd0;
               res_in.found = 1'b0;
               state_in = ST_EMIT;
            end else begin
               idx_in = next_idx(idx_ff);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_data = res_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= '0;
         last_time_ff <= 32'd0;
         scale_ff <= atb_pkg::TIME_SCALE_RESET;
         running_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         last_time_ff <= last_time_in;
         scale_ff <= scale_in;
         running_ff <= running_in;
      end
   end

   // Payload registers and channel storage.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      after_ff <= after_in;
      qdelta_ff <= qdelta_in;
      res_ff <= res_in;
      if (arr_we) begin
         rem_ff[arr_idx] <= rem_wdata;
      end
      if (tot_we) begin
         tot_ff[arr_idx] <= tot_wdata;
      end
   end

endmodule

[rtl/atb_rsp_queue.sv]
// Two-entry result queue between the back end and the result ports.
module atb_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  atb_pkg::result_type  push_data,
   output logic                 full,
   output logic                 empty,
   input  logic                 pop,
   output atb_pkg::result_type  head
);

   atb_pkg::result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   // Pointer and fill tracking.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/animation_timer_bank.sv]
// Top level of the animation timer bank: front end, back end, divider and result queue.
// Items run one at a time; start and stop take effect in the cycle after their transfer.
// A find scans one channel per cycle, then emits its result through the result queue.
// A tick runs the scale divide, then walks the channels: it skips idle ones, emits those
// that complete and runs a progress divide for running ones; a full result queue stalls it.
// Synchronous reset stops all channels, zeroes the last time, sets time_scale 1, running 1.
`include "animation_timer_bank_defines.svh"

module animation_timer_bank #(
   parameter int CHANNELS = atb_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_channel,
   input  logic [15:0] req_duration,
   input  logic [31:0] req_now_ms,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic [5:0]  rsp_channel_index,
   output logic [1:0]  rsp_phase,
   output logic [16:0] rsp_progress,
   output logic        rsp_found,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic                  item_valid;
   logic                  item_take;
   atb_pkg::item_type     item;
   atb_pkg::div_req_type  div_req;
   atb_pkg::div_rsp_type  div_rsp;
   logic                  rsp_push;
   logic                  rsp_full;
   atb_pkg::result_type   rsp_data;
   atb_pkg::result_type   rsp_head;

   atb_front #(.CHANNELS(CHANNELS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_kind     (req_kind),
      .req_channel  (req_channel),
      .req_duration (req_duration),
      .req_now_ms   (req_now_ms),
      .item_valid   (item_valid),
      .item         (item),
      .item_take    (item_take)
   );

   atb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   atb_back #(.CHANNELS(CHANNELS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data),
      .rsp_full   (rsp_full)
   );

   atb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (rsp_head)
   );

   // Result ports come straight from the queue head.
   assign rsp_result_kind = rsp_head.result_kind;
   assign rsp_channel_index = rsp_head.channel_index;
   assign rsp_phase = rsp_head.phase;
   assign rsp_progress = rsp_head.progress;
   assign rsp_found = rsp_head.found;
   assign rsp_last = rsp_head.last;

   // Internal consistency checks.
   `ATB_ASSERT_SAME(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy)
   `ATB_ASSERT_NEXT(a_div_busy_after_start, clock, reset, div_req.start, div_rsp.busy)
   `ATB_ASSERT_SAME(a_push_not_full, clock, reset, rsp_push, !rsp_full)
   `ATB_ASSERT_SAME(a_take_valid, clock, reset, item_take, item_valid)

endmodule

[sim/testbench.sv]
// Self-checking testbench for the animation timer bank: queued stimulus, scoreboard, config phases.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH = atb_pkg::CHANNELS_DEF;
   localparam int LIMIT_CYCLES = 1500000;

   typedef struct {
      logic [1:0]  kind;
      logic [5:0]  channel;
      logic [15:0] duration;
      logic [31:0] now_ms;
   } cmd_type;

   typedef struct {
      logic        result_kind;
      logic [5:0]  channel_index;
      logic [1:0]  phase;
      logic [16:0] progress;
      logic        found;
      logic        last;
   } update_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_kind;
   logic [5:0]  req_channel;
   logic [15:0] req_duration;
   logic [31:0] req_now_ms;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_result_kind;
   logic [5:0]  rsp_channel_index;
   logic [1:0]  rsp_phase;
   logic [16:0] rsp_progress;
   logic        rsp_found;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   animation_timer_bank dut (.*);

   // Shadow state of the channel bank.
   logic [15:0] shadow_remaining [NCH];
   logic [15:0] shadow_total [NCH];
   int unsigned shadow_active;
   logic [31:0] shadow_last_time;
   logic [15:0] shadow_scale;
   logic        shadow_running;

   cmd_type    pending_cmds[$];
   update_type expected_updates[$];
   int      error_count;
   int      cycle_count;
   int      update_count;
   int      drive_wait;
   int      pop_wait;
   logic [31:0] sim_now;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void shadow_stop(int unsigned n);
      if (n < NCH && shadow_remaining[n] != 0) begin
         shadow_active--;
         shadow_remaining[n] = 0;
      end
   endfunction

   // Predict the updates caused by one accepted command.
   function automatic void predict_updates(cmd_type c);
      logic [31:0] delta;
      logic [31:0] rem;
      logic [31:0] tot;
      logic [63:0] prog;
      int unsigned after;
      int unsigned nxt;
      int          first_idx;
      update_type  u;
      case (c.kind)
         atb_pkg::KIND_TICK: begin
            if (!shadow_running) return;
            delta = c.now_ms - shadow_last_time;
            if (delta < shadow_scale) return;
            delta = delta / shadow_scale;
            first_idx = expected_updates.size();
            for (int i = 0; i < NCH; i++) begin
               rem = shadow_remaining[i];
               tot = shadow_total[i];
               if (rem == 0) continue;
               u.result_kind = atb_pkg::RK_UPDATE;
               u.channel_index = 6'(i);
               u.found = 1'b0;
               u.last = 1'b0;
               if (rem > delta) begin
                  u.phase = (rem == tot) ? atb_pkg::PHASE_STARTED : atb_pkg::PHASE_PROGRESS;
                  prog = 0;
                  if (tot != 0 && tot >= rem) prog = (64'(tot - rem) << 16) / tot;
                  u.progress = prog[16:0];
                  shadow_remaining[i] = 16'(rem - delta);
               end else begin
                  shadow_stop(i);
                  u.phase = atb_pkg::PHASE_COMPLETED;
                  u.progress = atb_pkg::PROGRESS_FULL;
               end
               expected_updates.push_back(u);
            end
            if (expected_updates.size() > first_idx)
               expected_updates[expected_updates.size() - 1].last = 1'b1;
            shadow_last_time = c.now_ms;
         end
         atb_pkg::KIND_START: begin
            if (c.channel >= NCH) return;
            if (shadow_active == 0) shadow_last_time = c.now_ms;
            shadow_stop(c.channel);
            shadow_total[c.channel[3:0]] = (c.duration == 0) ? 16'd1 : c.duration;
            shadow_remaining[c.channel[3:0]] = shadow_total[c.channel[3:0]];
            shadow_active++;
         end
         atb_pkg::KIND_STOP: shadow_stop(c.channel);
         default: begin
            after = (c.channel >= NCH) ? NCH - 1 : c.channel;
            nxt = after;
            u = '{atb_pkg::RK_FIND, 6'd0, atb_pkg::PHASE_STARTED, 17'd0, 1'b0, 1'b1};
            do begin
               nxt = (nxt + 1) % NCH;
               if (shadow_remaining[nxt] == 0) begin
                  u.channel_index = 6'(nxt);
                  u.found = 1'b1;
                  break;
               end
            end while (nxt != after);
            expected_updates.push_back(u);
         end
      endcase
   endfunction

   // Driver: one transfer per command, random gap before each.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         drive_wait <= $urandom_range(0, 15);
      end else if (req_push && !req_full) begin
         predict_updates('{req_kind, req_channel, req_duration, req_now_ms});
         void'(pending_cmds.pop_front());
         drive_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
         req_push <= 1'b0;
      end else if (!req_push && pending_cmds.size() > 0) begin
         if (drive_wait > 0) begin
            drive_wait <= drive_wait - 1;
         end else begin
            req_push <= 1'b1;
            req_kind <= pending_cmds[0].kind;
            req_channel <= pending_cmds[0].channel;
            req_duration <= pending_cmds[0].duration;
            req_now_ms <= pending_cmds[0].now_ms;
         end
      end
   end

   // Monitor: random pop stalls, compare each transfer with the oldest expectation.
   always @(posedge clock) begin
      update_type e;
      int bad;
      bad = 0;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_wait <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            update_count <= update_count + 1;
            if (expected_updates.size() == 0) begin
               $error("unexpected result: channel_index %0d", rsp_channel_index);
               bad++;
            end else begin
               e = expected_updates.pop_front();
               if (e.result_kind !== rsp_result_kind) begin
                  $error("result_kind exp %0d got %0d", e.result_kind, rsp_result_kind);
                  bad++;
               end
               if (e.channel_index !== rsp_channel_index) begin
                  $error("channel_index exp %0d got %0d", e.channel_index, rsp_channel_index);
                  bad++;
               end
               if (e.phase !== rsp_phase) begin
                  $error("phase exp %0d got %0d", e.phase, rsp_phase);
                  bad++;
               end
               if (e.progress !== rsp_progress) begin
                  $error("progress exp %0d got %0d", e.progress, rsp_progress);
                  bad++;
               end
               if (e.found !== rsp_found) begin
                  $error("found exp %0d got %0d", e.found, rsp_found);
                  bad++;
               end
               if (e.last !== rsp_last) begin
                  $error("last exp %0d got %0d", e.last, rsp_last);
                  bad++;
               end
            end
            if (bad != 0) error_count <= error_count + bad;
            rsp_pop <= 1'b0;
            pop_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
         end else if (!rsp_pop) begin
            if (pop_wait > 0) pop_wait <= pop_wait - 1;
            else rsp_pop <= 1'b1;
         end
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic void queue_cmd(logic [1:0] k, logic [5:0] ch, logic [15:0] dur,
                                     logic [31:0] now);
      pending_cmds.push_back('{k, ch, dur, now});
   endfunction

   // Advance the stimulus clock and queue a tick at the new time.
   function automatic void queue_tick(logic [31:0] step);
      sim_now = sim_now + step;
      queue_cmd(atb_pkg::KIND_TICK, 6'($urandom), 16'($urandom), sim_now);
   endfunction

   // Write one register while the block is idle; updates the shadow copy on transfer.
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == atb_pkg::REG_TIME_SCALE)
         shadow_scale = (val == 0) ? 16'd1 :
                        (val > atb_pkg::TIME_SCALE_MAX ? atb_pkg::TIME_SCALE_MAX : val);
      else
         shadow_running = val[0];
   endtask

   // Wait until all commands are accepted and every expected update has arrived.
   task automatic drain();
      while (pending_cmds.size() > 0 || req_push || expected_updates.size() > 0)
         @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   // One random phase: mostly starts and ticks on small durations, with noise.
   task automatic random_phase(int n, int max_step);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35)
            queue_cmd(atb_pkg::KIND_START, 6'($urandom_range(0, 19)),
                      $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)),
                      sim_now);
         else if (r < 75)
            queue_tick($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, max_step));
         else if (r < 87)
            queue_cmd(atb_pkg::KIND_STOP, 6'($urandom_range(0, 20)), 16'($urandom), $urandom);
         else queue_cmd(atb_pkg::KIND_FIND, 6'($urandom), 16'($urandom), $urandom);
      end
      drain();
   endtask

   // Main sequence.
   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_kind = atb_pkg::KIND_TICK;
      req_channel = '0;
      req_duration = '0;
      req_now_ms = '0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_index = atb_pkg::REG_TIME_SCALE;
      csr_data = '0;
      error_count = 0;
      cycle_count = 0;
      update_count = 0;
      sim_now = 0;
      for (int i = 0; i < NCH; i++) begin
         shadow_remaining[i] = 0;
         shadow_total[i] = 0;
      end
      shadow_active = 0;
      shadow_last_time = 0;
      shadow_scale = atb_pkg::TIME_SCALE_RESET;
      shadow_running = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty find, bad channels, zero and full durations, all-busy find.
      queue_cmd(atb_pkg::KIND_FIND, 6'd63, 16'd0, 32'd0);
      queue_tick(32'd5);
      queue_cmd(atb_pkg::KIND_START, 6'd63, 16'd5, 32'd0);
      queue_cmd(atb_pkg::KIND_START, 6'd0, 16'd0, 32'hFFFF_FFF0);
      sim_now = 32'hFFFF_FFF0;
      queue_cmd(atb_pkg::KIND_START, 6'd15, 16'hFFFF, sim_now);
      queue_cmd(atb_pkg::KIND_START, 6'd7, 16'd4, sim_now);
      queue_cmd(atb_pkg::KIND_START, 6'd7, 16'd3, sim_now);
      queue_cmd(atb_pkg::KIND_FIND, 6'd15, 16'd0, 32'd0);
      queue_cmd(atb_pkg::KIND_FIND, 6'd6, 16'd0, 32'd0);
      queue_tick(32'd0);
      queue_tick(32'd1);
      queue_tick(32'd20);
      queue_cmd(atb_pkg::KIND_STOP, 6'd63, 16'd0, 32'd0);
      queue_cmd(atb_pkg::KIND_STOP, 6'd15, 16'd0, 32'd0);
      for (int i = 0; i < NCH; i++)
         queue_cmd(atb_pkg::KIND_START, 6'(i), 16'(i + 2), sim_now);
      queue_cmd(atb_pkg::KIND_FIND, 6'd3, 16'd0, 32'd0);
      queue_tick(32'd1);
      drain();

      // Random phases over several register settings, extremes included.
      random_phase(40, 8);
      write_reg(atb_pkg::REG_TIME_SCALE, 16'd0);
      write_reg(atb_pkg::REG_RUNNING, 16'd0);
      random_phase(20, 8);
      write_reg(atb_pkg::REG_RUNNING, 16'hFFFF);
      write_reg(atb_pkg::REG_TIME_SCALE, 16'd7);
      random_phase(40, 60);
      write_reg(atb_pkg::REG_TIME_SCALE, 16'hFFFF);
      random_phase(30, 200000);
      write_reg(atb_pkg::REG_TIME_SCALE, 16'd32768);
      write_reg(atb_pkg::REG_RUNNING, 16'd1);
      random_phase(20, 100000);
      write_reg(atb_pkg::REG_TIME_SCALE, 16'd1);
      random_phase(40, 10);

      $display("covered %0d results over tick, start, stop and find across six settings",
               update_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
